@@ design/pcc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants for the polygon convexity checker.
// ----------------------------------------------------------------------------
package pcc_pkg;

  typedef logic [1:0] pcc_count_t;

  localparam pcc_count_t SEEN_NONE = 2'd0;
  localparam pcc_count_t SEEN_ONE  = 2'd1;
  localparam pcc_count_t SEEN_TWO  = 2'd2;
  localparam pcc_count_t SEEN_FULL = 2'd3;

  // per-vertex control carried down the pipeline
  typedef struct packed {
    logic has_main;   // a triple ends at this vertex
    logic is_ref;     // that triple sets the reference class
    logic last;       // final vertex of the polygon
    logic few;        // fewer than three vertices so far, counting this one
  } pcc_flags_t;

endpackage

@@ design/pcc_if.sv @@
// ----------------------------------------------------------------------------
// pcc_if
// Valid/ready channels: vertex stream in, convexity result out.
// ----------------------------------------------------------------------------
interface pcc_vertex_if #(
  parameter int COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] vertex_x;
  logic signed [COORD_WIDTH-1:0] vertex_y;
  logic                          last_vertex;

  modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                  input ready);
  modport sink   (input valid, input vertex_x, input vertex_y, input last_vertex,
                  output ready);
endinterface

interface pcc_result_if;
  logic valid;
  logic ready;
  logic is_convex;
  logic too_few;

  modport source (output valid, output is_convex, output too_few, input ready);
  modport sink   (input valid, input is_convex, input too_few, output ready);
endinterface

@@ design/polygon_convexity_check.sv @@
// a vertex passes the stage 1 and stage 2 registers before the result output register
// throughput: one vertex per cycle when not stalled; the six cross-product multipliers are pipelined
// a waiting result stalls the pipe only once both internal stages are full
// and the second one holds a final vertex
// reset: synchronous, clears vertex count, stage valids, result valid and class state
// ----------------------------------------------------------------------------
// polygon_convexity_check
// Checks that every cyclic vertex triple of a polygon turns the same way.
// ----------------------------------------------------------------------------
module polygon_convexity_check
  import pcc_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  pcc_vertex_if.sink   vertices,
  pcc_result_if.source results
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;

  // vertex history
  logic signed [COORD_WIDTH-1:0] first_x, first_y, second_x, second_y;
  logic signed [COORD_WIDTH-1:0] older_x, older_y, newer_x, newer_y;
  pcc_count_t                    seen_count;

  // stage 1: differences
  logic                 v1;
  pcc_flags_t           f1;
  logic signed [DW-1:0] m_ax, m_ay, m_bx, m_by;
  logic signed [DW-1:0] w1_ax, w1_ay, w1_bx, w1_by;
  logic signed [DW-1:0] w2_ax, w2_ay, w2_bx, w2_by;

  // stage 2: products
  logic                 v2;
  pcc_flags_t           f2;
  logic signed [PW-1:0] m_l, m_r, w1_l, w1_r, w2_l, w2_r;

  // class state
  logic reference_positive;
  logic all_agree;

  logic out_free, ready2, fire_in, adv1;
  logic signed [DW-1:0] cx, cy;
  logic signed [DW-1:0] ex_first, ey_first, ex_second, ey_second;
  logic signed [DW-1:0] ex_older, ey_older, ex_newer, ey_newer;
  pcc_flags_t flags_in;

  logic cls_m, cls_w1, cls_w2, ref_next, agree_next, agree_final;

  assign out_free         = !results.valid || results.ready;
  assign ready2           = !v2 || !f2.last || out_free;
  assign adv1             = !v1 || ready2;
  assign vertices.ready   = adv1;
  assign fire_in          = vertices.valid && vertices.ready;

  assign cx        = DW'(vertices.vertex_x);
  assign cy        = DW'(vertices.vertex_y);
  assign ex_first  = DW'(first_x);
  assign ey_first  = DW'(first_y);
  assign ex_second = DW'(second_x);
  assign ey_second = DW'(second_y);
  assign ex_older  = DW'(older_x);
  assign ey_older  = DW'(older_y);
  assign ex_newer  = DW'(newer_x);
  assign ey_newer  = DW'(newer_y);

  always_comb begin
    flags_in.has_main = (seen_count == SEEN_TWO) || (seen_count == SEEN_FULL);
    flags_in.is_ref   = (seen_count == SEEN_TWO);
    flags_in.last     = vertices.last_vertex;
    flags_in.few      = (seen_count == SEEN_NONE) || (seen_count == SEEN_ONE);
  end

  // vertex history and count
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_count <= SEEN_NONE;
    end else if (fire_in) begin
      if (vertices.last_vertex) begin
        seen_count <= SEEN_NONE;
      end else if (seen_count != SEEN_FULL) begin
        seen_count <= seen_count + pcc_count_t'(1);
      end
    end
    if (fire_in) begin
      if (seen_count == SEEN_NONE) begin
        first_x <= vertices.vertex_x;
        first_y <= vertices.vertex_y;
      end
      if (seen_count == SEEN_ONE) begin
        second_x <= vertices.vertex_x;
        second_y <= vertices.vertex_y;
      end
      older_x <= newer_x;
      older_y <= newer_y;
      newer_x <= vertices.vertex_x;
      newer_y <= vertices.vertex_y;
    end
  end

  // stage 1: edge vectors for the triple ending here and the two wrap triples
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv1) begin
      v1 <= vertices.valid;
    end
    if (adv1) begin
      f1    <= flags_in;
      m_ax  <= ex_older - ex_newer;
      m_ay  <= ey_older - ey_newer;
      m_bx  <= ex_newer - cx;
      m_by  <= ey_newer - cy;
      w1_ax <= ex_newer - cx;
      w1_ay <= ey_newer - cy;
      w1_bx <= cx - ex_first;
      w1_by <= cy - ey_first;
      w2_ax <= cx - ex_first;
      w2_ay <= cy - ey_first;
      w2_bx <= ex_first - ex_second;
      w2_by <= ey_first - ey_second;
    end
  end

  // stage 2: cross-product terms
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ready2) begin
      v2 <= v1;
    end
    if (ready2) begin
      f2   <= f1;
      m_l  <= PW'(m_ax) * PW'(m_by);
      m_r  <= PW'(m_ay) * PW'(m_bx);
      w1_l <= PW'(w1_ax) * PW'(w1_by);
      w1_r <= PW'(w1_ay) * PW'(w1_bx);
      w2_l <= PW'(w2_ax) * PW'(w2_by);
      w2_r <= PW'(w2_ay) * PW'(w2_bx);
    end
  end

  // classify; zero counts as not positive
  always_comb begin
    cls_m       = m_l > m_r;
    cls_w1      = w1_l > w1_r;
    cls_w2      = w2_l > w2_r;
    ref_next    = f2.is_ref ? cls_m : reference_positive;
    agree_next  = all_agree && (!f2.has_main || f2.is_ref || (cls_m == reference_positive));
    agree_final = agree_next && (cls_w1 == ref_next) && (cls_w2 == ref_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_positive <= 1'b0;
      all_agree          <= 1'b1;
      results.valid      <= 1'b0;
    end else begin
      if (results.ready) begin
        results.valid <= 1'b0;
      end
      if (v2 && ready2) begin
        if (f2.last) begin
          results.valid      <= 1'b1;
          reference_positive <= 1'b0;
          all_agree          <= 1'b1;
        end else begin
          reference_positive <= ref_next;
          all_agree          <= agree_next;
        end
      end
    end
    if (v2 && ready2 && f2.last) begin
      results.is_convex <= !f2.few && agree_final;
      results.too_few   <= f2.few;
    end
  end

endmodule

@@ bench/pcc_convexity_checker.sv @@
// ----------------------------------------------------------------------------
// pcc_convexity_checker
// Watches the vertex and result channels, keeps its own copy of the turn
// tracking state, predicts one verdict per polygon and checks each result
// transfer against the oldest verdict still waiting.
// ----------------------------------------------------------------------------
module pcc_convexity_checker
  import pcc_pkg::*;
#(
  parameter int COORD_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          vertex_valid,
  input  logic                          vertex_ready,
  input  logic signed [COORD_WIDTH-1:0] vertex_x,
  input  logic signed [COORD_WIDTH-1:0] vertex_y,
  input  logic                          last_vertex,
  input  logic                          result_valid,
  input  logic                          result_ready,
  input  logic                          is_convex,
  input  logic                          too_few,
  output int                            pending,
  output int                            mismatches
);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef struct packed {
    logic is_convex;
    logic too_few;
  } verdict_t;

  verdict_t   expected_verdicts[$];
  int         fail_tally = 0;

  // turn tracking for the polygon in progress
  coord_t     head_x, head_y, next_x, next_y;
  coord_t     prev_x, prev_y, curr_x, curr_y;
  pcc_count_t seen;
  logic       ref_left;
  logic       consistent;

  // true when (p-q)x(q-r) is strictly above zero
  function automatic logic left_turn(input coord_t px, input coord_t py,
                                     input coord_t qx, input coord_t qy,
                                     input coord_t rx, input coord_t ry);
    logic signed [COORD_WIDTH:0]     ax, ay, bx, by;
    logic signed [2*COORD_WIDTH+1:0] lhs, rhs;
    ax  = px - qx;
    ay  = py - qy;
    bx  = qx - rx;
    by  = qy - ry;
    lhs = ax * by;
    rhs = ay * bx;
    return lhs > rhs;
  endfunction

  task automatic clear_polygon();
    head_x = '0; head_y = '0; next_x = '0; next_y = '0;
    prev_x = '0; prev_y = '0; curr_x = '0; curr_y = '0;
    seen       = SEEN_NONE;
    ref_left   = 1'b0;
    consistent = 1'b1;
  endtask

  task automatic absorb_vertex(input coord_t cx, input coord_t cy, input logic last);
    pcc_count_t prior;
    logic       turn;
    verdict_t   verdict;
    prior = seen;
    case (prior)
      SEEN_NONE: begin
        head_x = cx;
        head_y = cy;
      end
      SEEN_ONE: begin
        next_x = cx;
        next_y = cy;
      end
      default: begin
        turn = left_turn(prev_x, prev_y, curr_x, curr_y, cx, cy);
        if (prior == SEEN_TWO) begin
          ref_left = turn;
        end else if (turn != ref_left) begin
          consistent = 1'b0;
        end
      end
    endcase
    prev_x = curr_x;
    prev_y = curr_y;
    curr_x = cx;
    curr_y = cy;
    if (seen != SEEN_FULL) begin
      seen = seen + 2'd1;
    end
    if (last) begin
      if (prior == SEEN_NONE || prior == SEEN_ONE) begin
        verdict.is_convex = 1'b0;
        verdict.too_few   = 1'b1;
      end else begin
        // the two triples that wrap round to the first vertices
        if (left_turn(prev_x, prev_y, cx, cy, head_x, head_y) != ref_left) begin
          consistent = 1'b0;
        end
        if (left_turn(cx, cy, head_x, head_y, next_x, next_y) != ref_left) begin
          consistent = 1'b0;
        end
        verdict.is_convex = consistent;
        verdict.too_few   = 1'b0;
      end
      expected_verdicts.push_back(verdict);
      clear_polygon();
    end
  endtask

  task automatic check_result(input logic got_convex, input logic got_few);
    verdict_t want;
    if (expected_verdicts.size() == 0) begin
      $error("result transfer with no verdict waiting: is_convex %0b too_few %0b",
             got_convex, got_few);
      fail_tally++;
    end else begin
      want = expected_verdicts.pop_front();
      if (got_convex !== want.is_convex) begin
        $error("is_convex: expected %0b, got %0b", want.is_convex, got_convex);
        fail_tally++;
      end
      if (got_few !== want.too_few) begin
        $error("too_few: expected %0b, got %0b", want.too_few, got_few);
        fail_tally++;
      end
    end
  endtask

  initial begin
    clear_polygon();
    pending    = 0;
    mismatches = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      expected_verdicts.delete();
      clear_polygon();
    end else begin
      if (vertex_valid && vertex_ready) begin
        absorb_vertex(vertex_x, vertex_y, last_vertex);
      end
      if (result_valid && result_ready) begin
        check_result(is_convex, too_few);
      end
    end
    pending    <= expected_verdicts.size();
    mismatches <= fail_tally;
  end

endmodule

@@ bench/tb_polygon_convexity_check.sv @@
// ----------------------------------------------------------------------------
// tb_polygon_convexity_check
// Feeds directed and random polygons (convex rings, scattered points, full
// range wraps, collinear runs and too-short polygons) through the vertex
// channel with random gaps and result back-pressure, and reports the verdict
// of the checker.
// ----------------------------------------------------------------------------
module tb_polygon_convexity_check;
  import pcc_pkg::*;

  localparam int COORD_WIDTH  = 16;
  localparam int RANDOM_ITEMS = 1050;
  localparam int BUSY_PCT     = 17;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  int     idle_pct  = BUSY_PCT;
  int     stall_pct = BUSY_PCT;
  int     pending;
  int     mismatches;
  int     items_sent = 0;
  coord_t ring_x[$];
  coord_t ring_y[$];

  pcc_vertex_if #(.COORD_WIDTH(COORD_WIDTH)) vertices ();
  pcc_result_if                              results ();

  polygon_convexity_check #(.COORD_WIDTH(COORD_WIDTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .vertices (vertices),
    .results  (results)
  );

  pcc_convexity_checker #(.COORD_WIDTH(COORD_WIDTH)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .vertex_valid (vertices.valid),
    .vertex_ready (vertices.ready),
    .vertex_x     (vertices.vertex_x),
    .vertex_y     (vertices.vertex_y),
    .last_vertex  (vertices.last_vertex),
    .result_valid (results.valid),
    .result_ready (results.ready),
    .is_convex    (results.is_convex),
    .too_few      (results.too_few),
    .pending      (pending),
    .mismatches   (mismatches)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    results.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_vertex(input coord_t x, input coord_t y, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      vertices.valid <= 1'b0;
      @(posedge clk);
    end
    vertices.valid       <= 1'b1;
    vertices.vertex_x    <= x;
    vertices.vertex_y    <= y;
    vertices.last_vertex <= last;
    do @(posedge clk); while (!vertices.ready);
    items_sent++;
  endtask

  task automatic add_vertex(input int x, input int y);
    ring_x.push_back(coord_t'(x));
    ring_y.push_back(coord_t'(y));
  endtask

  task automatic send_polygon();
    for (int i = 0; i < ring_x.size(); i++) begin
      send_vertex(ring_x[i], ring_y[i], i == ring_x.size() - 1);
    end
    ring_x.delete();
    ring_y.delete();
  endtask

  // stop feeding and let every outstanding verdict come out
  task automatic drain_results();
    vertices.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // points on a circle in angular order, so convex up to rounding
  task automatic make_convex(input int n);
    real step[16];
    real total, angle, radius, turn_dir;
    int  cx, cy;
    total = 0.0;
    for (int i = 0; i < n; i++) begin
      step[i] = 1.0 + $urandom_range(99);
      total   = total + step[i];
    end
    if ($urandom_range(9) == 0) begin
      radius = $urandom_range(8, 1);
    end else begin
      radius = $urandom_range(16000, 20);
    end
    cx       = $urandom_range(32000) - 16000;
    cy       = $urandom_range(32000) - 16000;
    turn_dir = ($urandom_range(1) == 1) ? 1.0 : -1.0;
    angle    = $urandom_range(359) * 3.14159265 / 180.0;
    for (int i = 0; i < n; i++) begin
      add_vertex(cx + $rtoi(radius * $cos(angle)), cy + $rtoi(radius * $sin(angle)));
      angle = angle + turn_dir * 6.28318531 * step[i] / total;
    end
  endtask

  task automatic make_scatter(input int n, input int span);
    for (int i = 0; i < n; i++) begin
      add_vertex($urandom_range(2 * span) - span, $urandom_range(2 * span) - span);
    end
  endtask

  // raw 16-bit patterns, so every coordinate bit and wrap-round differences appear
  task automatic make_full_range(input int n);
    for (int i = 0; i < n; i++) begin
      add_vertex($urandom_range(65535), $urandom_range(65535));
    end
  endtask

  task automatic make_collinear(input int n);
    int x0, y0, dx, dy;
    x0 = $urandom_range(2000) - 1000;
    y0 = $urandom_range(2000) - 1000;
    dx = $urandom_range(40) - 20;
    dy = $urandom_range(40) - 20;
    for (int i = 0; i < n; i++) begin
      add_vertex(x0 + i * dx, y0 + i * dy);
    end
  endtask

  initial begin
    int polygons;
    int pick;
    vertices.valid       = 1'b0;
    vertices.vertex_x    = '0;
    vertices.vertex_y    = '0;
    vertices.last_vertex = 1'b0;
    results.ready        = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // lone vertex and a pair: both too short
    add_vertex(5, -5);
    send_polygon();
    add_vertex(-32768, 32767);
    add_vertex(32767, -32768);
    send_polygon();
    // counter-clockwise and clockwise triangles
    add_vertex(0, 0);
    add_vertex(10, 0);
    add_vertex(0, 10);
    send_polygon();
    add_vertex(0, 0);
    add_vertex(0, 10);
    add_vertex(10, 0);
    send_polygon();
    // square on the coordinate extremes
    add_vertex(-32768, -32768);
    add_vertex(32767, -32768);
    add_vertex(32767, 32767);
    add_vertex(-32768, 32767);
    send_polygon();
    // all turns zero, which classes as not positive
    add_vertex(0, 0);
    add_vertex(1, 1);
    add_vertex(2, 2);
    send_polygon();
    // dart with one reflex corner
    add_vertex(0, 0);
    add_vertex(10, 0);
    add_vertex(3, 3);
    add_vertex(0, 10);
    send_polygon();
    drain_results();

    polygons = 0;
    while (items_sent < RANDOM_ITEMS + 20) begin
      // one long stretch with neither gaps nor stalls
      if (polygons >= 40 && polygons < 75) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = BUSY_PCT;
        stall_pct = BUSY_PCT;
      end
      pick = $urandom_range(99);
      if (pick < 55) begin
        make_convex($urandom_range(10, 3));
      end else if (pick < 70) begin
        make_scatter($urandom_range(8, 3), 50);
      end else if (pick < 82) begin
        make_full_range($urandom_range(6, 1));
      end else if (pick < 91) begin
        make_scatter($urandom_range(2, 1), 32767);
      end else begin
        make_collinear($urandom_range(6, 3));
      end
      send_polygon();
      polygons++;
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
